@@ sv/cqd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cqd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;

    // request codes
    localparam logic [OP_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [OP_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [OP_W-1:0] REQ_DEDUP  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // one accepted request handed to the sequencer
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } req_t;

endpackage

`default_nettype wire

@@ sv/cqd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqd_ram
    import cqd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/cqd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqd_ctrl
    import cqd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire req_t              req,
    output logic                   idle,
    output logic                   res_valid,
    output logic      [STAT_W-1:0] res_status,
    output logic      [DATA_W-1:0] res_value,
    output logic      [CW-1:0]     res_occ
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEL  = 3'd1;
    localparam logic [2:0] S_RI   = 3'd2;
    localparam logic [2:0] S_LI   = 3'd3;
    localparam logic [2:0] S_CK   = 3'd4;
    localparam logic [2:0] S_KEEP = 3'd5;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     kept_reg, kept_next;
    logic [DATA_W-1:0] v_reg, v_next;

    logic [CW-1:0]     pos;
    logic [CW:0]       sum;
    logic [AW-1:0]     addr;
    logic              we;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    logic              last_i;

    // shared ring address unit: (head + pos) mod depth
    always_comb begin
        sum = {{(CW + 1 - AW){1'b0}}, head_reg} + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        addr = sum[AW-1:0];
    end

    cqd_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign idle   = (state_reg == S_IDLE);
    assign last_i = ((i_reg + CW'(1)) == count_reg);

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        kept_next  = kept_reg;
        v_next     = v_reg;
        pos        = count_reg;
        we         = 1'b0;
        wdata      = v_reg;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_value  = '0;
        res_occ    = count_reg;

        unique case (state_reg)
            S_IDLE: begin
                wdata = req.value;
                if (req.op == REQ_DELETE) begin
                    pos = '0;
                end
                if (req.valid) begin
                    unique case (req.op)
                        REQ_INSERT: begin
                            res_valid = 1'b1;
                            if (count_reg == FULL_CNT) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                                res_occ    = count_next;
                            end
                        end
                        REQ_DELETE: begin
                            if (count_reg == '0) begin
                                res_valid  = 1'b1;
                                res_status = ST_UNDERFLOW;
                            end else begin
                                count_next = count_reg - CW'(1);
                                if (count_next == '0) begin
                                    head_next = '0;
                                end else if (head_reg == LAST_IDX) begin
                                    head_next = '0;
                                end else begin
                                    head_next = head_reg + AW'(1);
                                end
                                state_next = S_DEL;
                            end
                        end
                        REQ_DEDUP: begin
                            if (count_reg == '0) begin
                                res_valid  = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                i_next     = '0;
                                kept_next  = '0;
                                state_next = S_RI;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DEL: begin
                res_valid  = 1'b1;
                res_value  = rdata;
                state_next = S_IDLE;
            end
            S_RI: begin
                pos        = i_reg;
                state_next = S_LI;
            end
            S_LI: begin
                // candidate arrives; start reading kept entry 0
                pos    = '0;
                v_next = rdata;
                k_next = '0;
                if (kept_reg == '0) begin
                    state_next = S_KEEP;
                end else begin
                    state_next = S_CK;
                end
            end
            S_CK: begin
                // compare kept entry k, prefetch entry k+1
                pos = k_reg + CW'(1);
                if (rdata == v_reg) begin
                    if (last_i) begin
                        res_valid  = 1'b1;
                        res_occ    = kept_reg;
                        count_next = kept_reg;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_RI;
                    end
                end else if ((k_reg + CW'(1)) == kept_reg) begin
                    state_next = S_KEEP;
                end else begin
                    k_next = k_reg + CW'(1);
                end
            end
            S_KEEP: begin
                pos       = kept_reg;
                we        = 1'b1;
                kept_next = kept_reg + CW'(1);
                if (last_i) begin
                    res_valid  = 1'b1;
                    res_occ    = kept_next;
                    count_next = kept_next;
                    state_next = S_IDLE;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_RI;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        i_reg    <= i_next;
        k_reg    <= k_next;
        kept_reg <= kept_next;
        v_reg    <= v_next;
    end

endmodule

`default_nettype wire

@@ sv/circular_queue_with_dedup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | tdata (low bit up)              | tuser
// s_axis    | in  | in_value[31:0]                  | req_type[1:0]
// m_axis    | out | out_value[31:0], occupancy, pad | status[1:0]
//
// insert and every rejected or empty request are answered from the idle state,
// delete waits in S_DEL for the ram read; dedup reads each entry, then compares
//   it to the kept entries in turn through the single ram port and comparator
// aresetn clears head, count and sequencer; the ring store itself is not cleared
// a waiting result on m_axis stalls input only while the next one could collide

module circular_queue_with_dedup
    import cqd_pkg::*;
#(
    parameter  int DEPTH   = DEPTH_DEF,
    localparam int AW      = $clog2(DEPTH),
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int TDATA_W = ((DATA_W + CW + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DATA_W-1:0]     s_axis_tdata,   // in_value
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // req_type

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,   // out_value, occupancy, zero pad
    output logic [STAT_W-1:0]          m_axis_tuser    // status
);

    req_t              req;
    logic              ctrl_idle;
    logic              res_valid;
    logic [STAT_W-1:0] res_status;
    logic [DATA_W-1:0] res_value;
    logic [CW-1:0]     res_occ;

    // output holding register
    logic              m_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     occ_reg;

    // take a transfer only when the sequencer is free and the output slot
    // is empty or being drained at this edge
    assign s_axis_tready = ctrl_idle && (!m_valid_reg || m_axis_tready);

    assign req.valid = s_axis_tvalid && s_axis_tready;
    assign req.op    = s_axis_tuser;
    assign req.value = s_axis_tdata;

    cqd_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .idle       (ctrl_idle),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_value  (res_value),
        .res_occ    (res_occ)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            priority if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            status_reg <= res_status;
            value_reg  <= res_value;
            occ_reg    <= res_occ;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = TDATA_W'({occ_reg, value_reg});

endmodule

`default_nettype wire
